// File: rtl/core/rwph_pkg.sv
// Shared types, constants and the CORDIC arctangent table of the patch hit tracker.
`timescale 1ns / 1ps

package rwph_pkg;

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W  = 5;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PATCH_X    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PATCH_Y    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PATCH_RAD  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PERCEPTION = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED      = 3'd4;

    localparam logic [31:0] SPEED_RESET = 32'h0001_0000;

    // Input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_MOVE  = 1'b1;

    // CORDIC: start vector (gain compensated, Q2.30) and internal width
    localparam int          TRIG_W       = 34;
    localparam logic [31:0] CORDIC_START = 32'd652032874;

    // Operand width of the shared multiplier
    localparam int MUL_W = 33;

    typedef struct packed {
        logic               action;
        logic [15:0]        start_heading;
        logic signed [15:0] turn_angle;
        logic [31:0]        step_length;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic [47:0] hit_time;
    } out_item_t;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10680862;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/random_walk_patch_hit_tracker_unit.sv
// Top level of the patch hit tracker: sequencer, walker state, config registers, result register.
`timescale 1ns / 1ps

// Follows one walker of a correlated random walk and reports when it first
// comes within patch_radius + perception_range of the patch centre. A start
// transfer puts the walker at the origin with zero elapsed time and loads its
// heading; each move transfer turns the heading, rotates a CORDIC vector to get
// cosine and sine, steps the position, adds speed_factor * step_length to the
// elapsed time and runs an exact squared-distance test. The first hit yields
// one result (hit = 1, elapsed time); a walker that never hits yields (0, 0)
// on its transfer marked last; all other transfers yield nothing. One item is
// worked on at a time and in_ready is low meanwhile. A move for a walker that
// has already finished is ignored. A move takes longer when the squared
// distance must be formed than when the walker is clearly outside the patch,
// and longer again when a result is handed to the output register. The
// iterative CORDIC and the shared 33 x 33 multiplier, used for up to six
// products, set how long a move takes. A finished result waits in the output
// register while the next item is taken. Configuration writes take effect at
// once and are meant for idle periods.
module random_walk_patch_hit_tracker_unit #(
    parameter int ANGLE_BITS      = 16,
    parameter int COORD_BITS      = 32,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rwph_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rwph_pkg::out_item_t               out_data,
    input  logic                              cfg_we,
    input  logic [rwph_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [rwph_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import rwph_pkg::*;

    localparam int DXW   = 35;                                   // displacement width
    localparam int WW    = ((COORD_BITS > DXW) ? COORD_BITS : DXW) + 1;
    localparam int DW    = ((COORD_BITS > 32) ? COORD_BITS : 32) + 1;
    localparam int PW    = 2 * MUL_W;
    localparam int HSH   = 32 - ANGLE_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_CORDIC, S_MUL_X, S_MUL_Y, S_MUL_T, S_POS,
        S_CHECK, S_SQ_X, S_SQ_Y, S_SQ_R, S_END, S_EMIT
    } state_t;

    // configuration
    logic signed [31:0]            patch_x_reg, patch_y_reg;
    logic [31:0]                   radius_reg, perception_reg, speed_reg;

    // walker state
    state_t                        state_reg;
    logic signed [COORD_BITS-1:0]  pos_x_reg, pos_y_reg;
    logic [ANGLE_BITS-1:0]         heading_reg;
    logic [47:0]                   elapsed_reg;
    logic                          walker_done_reg;

    // per-move working registers
    logic [31:0]                   step_reg;
    logic                          last_reg;
    logic                          issued_reg;
    logic signed [DXW-1:0]         dx_reg, dy_reg;
    logic [47:0]                   dt_reg;
    logic [MUL_W-1:0]              ax_reg, ay_reg, r_reg;
    logic [PW:0]                   sq_reg;
    logic                          hit_reg;
    out_item_t                     res_reg;

    // output register
    logic                          out_valid_reg;
    out_item_t                     out_data_reg;

    // unit connections
    logic                          cordic_start, cordic_done;
    logic signed [TRIG_W-1:0]      cos_val, sin_val;
    logic                          mul_start, mul_done;
    logic [MUL_W-1:0]              mul_a, mul_b;
    logic [PW-1:0]                 mul_p;

    // combinational helpers
    logic [31:0]                   head_wide, turn_wide, head_sum, start_wide;
    logic [ANGLE_BITS-1:0]         head_new, head_start;
    logic [31:0]                   cordic_angle;
    logic                          in_xfer, out_free;
    logic signed [TRIG_W-1:0]      trig_sel;
    logic [TRIG_W-1:0]             trig_abs;
    logic                          trig_neg;
    logic [DXW-1:0]                disp_mag;
    logic signed [DXW-1:0]         disp;
    logic signed [WW-1:0]          sum_x, sum_y;
    logic signed [COORD_BITS-1:0]  sat_x, sat_y;
    logic [48:0]                   time_sum;
    logic [47:0]                   time_sat;
    logic [MUL_W-1:0]              r_sum;
    logic signed [DW-1:0]          diff_x, diff_y;
    logic [DW-1:0]                 abs_x, abs_y, r_ext;
    logic                          near;

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [WW-1:0] v
    );
        logic [WW-COORD_BITS:0] hi;
        logic signed [COORD_BITS-1:0] r;
        hi = v[WW-1:COORD_BITS-1];
        if ((&hi) || (~|hi))
            r = v[COORD_BITS-1:0];
        else if (v[WW-1])
            r = {1'b1, {(COORD_BITS-1){1'b0}}};
        else
            r = {1'b0, {(COORD_BITS-1){1'b1}}};
        return r;
    endfunction

    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // heading arithmetic on a 32-bit turn scale, kept to ANGLE_BITS
    always_comb
    begin
        head_wide    = 32'(heading_reg) << HSH;
        turn_wide    = {in_data.turn_angle, 16'h0000};
        head_sum     = head_wide + turn_wide;
        head_new     = head_sum[31 -: ANGLE_BITS];
        start_wide   = {in_data.start_heading, 16'h0000};
        head_start   = start_wide[31 -: ANGLE_BITS];
        cordic_angle = 32'(head_new) << HSH;
    end

    // multiplier operand select
    always_comb
    begin
        trig_sel = (state_reg == S_MUL_Y) ? sin_val : cos_val;
        trig_neg = trig_sel[TRIG_W-1];
        trig_abs = trig_neg ? TRIG_W'(-trig_sel) : TRIG_W'(trig_sel);
        case (state_reg)
            S_MUL_X, S_MUL_Y:
            begin
                mul_a = MUL_W'(step_reg);
                mul_b = trig_abs[MUL_W-1:0];
            end
            S_MUL_T:
            begin
                mul_a = MUL_W'(speed_reg);
                mul_b = MUL_W'(step_reg);
            end
            S_SQ_X:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            S_SQ_Y:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            S_SQ_R:
            begin
                mul_a = r_reg;
                mul_b = r_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_start = !issued_reg && (state_reg inside {S_MUL_X, S_MUL_Y, S_MUL_T,
                                                      S_SQ_X, S_SQ_Y, S_SQ_R});
    end

    // displacement floor(step * trig / 2^30): round the magnitude up when negative
    always_comb
    begin
        disp_mag = DXW'(mul_p[63:30]) + DXW'(trig_neg && (|mul_p[29:0]));
        disp     = trig_neg ? -signed'(disp_mag) : signed'(disp_mag);
    end

    // position and time update, saturating
    always_comb
    begin
        sum_x    = WW'(pos_x_reg) + WW'(dx_reg);
        sum_y    = WW'(pos_y_reg) + WW'(dy_reg);
        sat_x    = sat_coord(sum_x);
        sat_y    = sat_coord(sum_y);
        time_sum = {1'b0, elapsed_reg} + {1'b0, dt_reg};
        time_sat = time_sum[48] ? {48{1'b1}} : time_sum[47:0];
    end

    // coarse distance check; only a candidate inside the box gets squared
    always_comb
    begin
        r_sum  = MUL_W'(radius_reg) + MUL_W'(perception_reg);
        diff_x = DW'(pos_x_reg) - DW'(patch_x_reg);
        diff_y = DW'(pos_y_reg) - DW'(patch_y_reg);
        abs_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
        abs_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
        r_ext  = DW'(r_sum);
        near   = (abs_x < r_ext) && (abs_y < r_ext);
    end

    rwph_cordic #(
        .ITERATIONS(TRIG_ITERATIONS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .done    (cordic_done),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    rwph_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign cordic_start = in_xfer && (in_data.action == ACT_MOVE) && !walker_done_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patch_x_reg    <= '0;
            patch_y_reg    <= '0;
            radius_reg     <= '0;
            perception_reg <= '0;
            speed_reg      <= SPEED_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PATCH_X:    patch_x_reg    <= signed'(cfg_wdata);
                REG_PATCH_Y:    patch_y_reg    <= signed'(cfg_wdata);
                REG_PATCH_RAD:  radius_reg     <= cfg_wdata;
                REG_PERCEPTION: perception_reg <= cfg_wdata;
                REG_SPEED:      speed_reg      <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // sequencer, walker state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            heading_reg     <= '0;
            elapsed_reg     <= '0;
            walker_done_reg <= 1'b1;
            step_reg        <= '0;
            last_reg        <= 1'b0;
            issued_reg      <= 1'b0;
            dx_reg          <= '0;
            dy_reg          <= '0;
            dt_reg          <= '0;
            ax_reg          <= '0;
            ay_reg          <= '0;
            r_reg           <= '0;
            sq_reg          <= '0;
            hit_reg         <= 1'b0;
            res_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            // the emit state reloads the output register itself
            if (out_valid_reg && out_ready && (state_reg != S_EMIT))
                out_valid_reg <= 1'b0;

            // a multiply is issued once per state and retired on done
            if (mul_done)
                issued_reg <= 1'b0;
            else if (mul_start)
                issued_reg <= 1'b1;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (in_data.action == ACT_START)
                        begin
                            pos_x_reg       <= '0;
                            pos_y_reg       <= '0;
                            elapsed_reg     <= '0;
                            heading_reg     <= head_start;
                            walker_done_reg <= 1'b0;
                            if (in_data.last)
                            begin
                                // start with no move: report a miss at once
                                walker_done_reg <= 1'b1;
                                res_reg         <= '0;
                                state_reg       <= S_EMIT;
                            end
                        end
                        else if (!walker_done_reg)
                        begin
                            heading_reg <= head_new;
                            step_reg    <= in_data.step_length;
                            last_reg    <= in_data.last;
                            hit_reg     <= 1'b0;
                            state_reg   <= S_CORDIC;
                        end
                    end
                end
                S_CORDIC:
                begin
                    if (cordic_done)
                        state_reg <= S_MUL_X;
                end
                S_MUL_X:
                begin
                    if (mul_done)
                    begin
                        dx_reg    <= disp;
                        state_reg <= S_MUL_Y;
                    end
                end
                S_MUL_Y:
                begin
                    if (mul_done)
                    begin
                        dy_reg    <= disp;
                        state_reg <= S_MUL_T;
                    end
                end
                S_MUL_T:
                begin
                    if (mul_done)
                    begin
                        dt_reg    <= mul_p[63:16];
                        state_reg <= S_POS;
                    end
                end
                S_POS:
                begin
                    pos_x_reg   <= sat_x;
                    pos_y_reg   <= sat_y;
                    elapsed_reg <= time_sat;
                    state_reg   <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (near)
                    begin
                        ax_reg    <= abs_x[MUL_W-1:0];
                        ay_reg    <= abs_y[MUL_W-1:0];
                        r_reg     <= r_sum;
                        state_reg <= S_SQ_X;
                    end
                    else
                    begin
                        state_reg <= S_END;
                    end
                end
                S_SQ_X:
                begin
                    if (mul_done)
                    begin
                        sq_reg    <= (PW + 1)'(mul_p);
                        state_reg <= S_SQ_Y;
                    end
                end
                S_SQ_Y:
                begin
                    if (mul_done)
                    begin
                        sq_reg    <= sq_reg + (PW + 1)'(mul_p);
                        state_reg <= S_SQ_R;
                    end
                end
                S_SQ_R:
                begin
                    if (mul_done)
                    begin
                        hit_reg   <= sq_reg < (PW + 1)'(mul_p);
                        state_reg <= S_END;
                    end
                end
                S_END:
                begin
                    if (hit_reg)
                    begin
                        walker_done_reg  <= 1'b1;
                        res_reg.hit      <= 1'b1;
                        res_reg.hit_time <= elapsed_reg;
                        state_reg        <= S_EMIT;
                    end
                    else if (last_reg)
                    begin
                        walker_done_reg <= 1'b1;
                        res_reg         <= '0;
                        state_reg       <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= res_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_miss_has_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.hit |-> out_data_reg.hit_time == 48'd0)
        else $error("miss result carries a nonzero time");

    a_cordic_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> state_reg == S_CORDIC)
        else $error("CORDIC finished outside its wait state");

    a_mul_done_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_MUL_X || state_reg == S_MUL_Y ||
                      state_reg == S_MUL_T || state_reg == S_SQ_X ||
                      state_reg == S_SQ_Y || state_reg == S_SQ_R) && issued_reg)
        else $error("multiplier result arrived with no product pending");

    a_emit_leaves_walker_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> walker_done_reg)
        else $error("result pending while walker still active");

endmodule

// File: rtl/core/rwph_cordic.sv
// Iterative CORDIC rotation: one micro-rotation per cycle, gives cosine and sine in Q2.30.
`timescale 1ns / 1ps

module rwph_cordic #(
    parameter int ITERATIONS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [31:0]                        angle,
    output logic                               done,
    output logic signed [rwph_pkg::TRIG_W-1:0] cos_val,
    output logic signed [rwph_pkg::TRIG_W-1:0] sin_val
);
    import rwph_pkg::*;

    localparam int CW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

    typedef enum logic {C_IDLE, C_RUN} cstate_t;

    cstate_t                  state_reg;
    logic [CW-1:0]            iter_reg;
    logic                     flip_reg;
    logic signed [TRIG_W-1:0] x_reg;
    logic signed [TRIG_W-1:0] y_reg;
    logic signed [TRIG_W-1:0] z_reg;
    logic                     done_reg;

    logic [31:0]              rot_sum;
    logic                     flip;
    logic [31:0]              folded;
    logic signed [TRIG_W-1:0] x_sh, y_sh, step_ang;
    logic signed [TRIG_W-1:0] nx, ny, nz;
    logic                     dir;

    always_comb
    begin
        rot_sum  = angle + 32'h4000_0000;
        flip     = rot_sum[31];
        folded   = flip ? (angle ^ 32'h8000_0000) : angle;
        dir      = ~z_reg[TRIG_W-1];
        x_sh     = x_reg >>> iter_reg;
        y_sh     = y_reg >>> iter_reg;
        step_ang = signed'(TRIG_W'(atan_turn(ATAN_IDX_W'(iter_reg))));
        nx       = dir ? (x_reg - y_sh) : (x_reg + y_sh);
        ny       = dir ? (y_reg + x_sh) : (y_reg - x_sh);
        nz       = dir ? (z_reg - step_ang) : (z_reg + step_ang);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            iter_reg  <= '0;
            flip_reg  <= 1'b0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        flip_reg  <= flip;
                        x_reg     <= signed'(TRIG_W'(CORDIC_START));
                        y_reg     <= '0;
                        z_reg     <= TRIG_W'(signed'(folded));
                        iter_reg  <= '0;
                        state_reg <= C_RUN;
                    end
                end
                C_RUN:
                begin
                    z_reg <= nz;
                    if (iter_reg == CW'(ITERATIONS - 1))
                    begin
                        // fold back the half-turn rotation on the last step
                        x_reg     <= flip_reg ? -nx : nx;
                        y_reg     <= flip_reg ? -ny : ny;
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                    else
                    begin
                        x_reg    <= nx;
                        y_reg    <= ny;
                        iter_reg <= iter_reg + 1'b1;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done    = done_reg;
    assign cos_val = x_reg;
    assign sin_val = y_reg;

endmodule

// File: rtl/core/rwph_mul.sv
// Shared unsigned multiplier: 33 x 33 bits, one 11-bit slice of the second operand per cycle.
`timescale 1ns / 1ps

module rwph_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rwph_pkg::MUL_W-1:0]    op_a,
    input  logic [rwph_pkg::MUL_W-1:0]    op_b,
    output logic                          done,
    output logic [2*rwph_pkg::MUL_W-1:0]  product
);
    import rwph_pkg::*;

    localparam int SLICE   = 11;
    localparam int NSLICES = MUL_W / SLICE;
    localparam int PW      = 2 * MUL_W;

    typedef enum logic {M_IDLE, M_RUN} mstate_t;

    mstate_t                 state_reg;
    logic [1:0]              cnt_reg;
    logic [MUL_W-1:0]        a_reg;
    logic [MUL_W-1:0]        b_reg;
    logic [PW-1:0]           acc_reg;
    logic                    done_reg;

    logic [SLICE-1:0]        b_slice;
    logic [MUL_W+SLICE-1:0]  partial;
    logic [PW-1:0]           acc_sum;

    always_comb
    begin
        b_slice = b_reg[SLICE-1:0];
        partial = (MUL_W + SLICE)'(a_reg) * (MUL_W + SLICE)'(b_slice);
        acc_sum = acc_reg + (PW'(partial) << (SLICE * cnt_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            acc_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= op_a;
                        b_reg     <= op_b;
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= M_RUN;
                    end
                end
                M_RUN:
                begin
                    acc_reg <= acc_sum;
                    b_reg   <= b_reg >> SLICE;
                    if (cnt_reg == 2'(NSLICES - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// File: sim/random_walk_patch_hit_tracker_unit_tb.sv
// Self-checking testbench of the patch hit tracker: directed table, random walkers, stalls.
`timescale 1ns / 1ps

module random_walk_patch_hit_tracker_unit_tb;
    import rwph_pkg::*;

    // Drop the run after this many cycles with no transfer on either channel.
    localparam int STALL_LIMIT  = 5000;
    // Settle for longer than the longest move lasts.
    localparam int SETTLE_CYC   = 80;
    localparam int PHASE_ITEMS  = 100;
    localparam int NUM_PHASES   = 8;
    localparam int LONG_HOLD    = 400;

    // Arctangent of 2^-i in 2^-32 turn, first 16 entries.
    localparam longint ATAN_TURNS [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    typedef struct {
        in_item_t  item;
        bit        typed;       // expectation typed in below, not predicted
        out_item_t want;
        bit        reconfig;    // settle and load the directed patch first
    } stim_row_t;

    typedef struct {
        bit        typed;
        out_item_t want;
    } item_tag_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Mirror of the configuration registers
    longint    patch_cx   = 0;
    longint    patch_cy   = 0;
    bit [31:0] patch_rad  = 0;
    bit [31:0] sense_rng  = 0;
    bit [31:0] time_rate  = SPEED_RESET;

    // Mirror of the walker
    longint    walk_x     = 0;
    longint    walk_y     = 0;
    bit [15:0] walk_hdg   = 0;
    bit [63:0] walk_time  = 0;
    bit        walk_over  = 1'b1;

    out_item_t pending_results [$];
    item_tag_t item_tags [$];
    stim_row_t directed [$];
    int        errors     = 0;
    int        quiet_cyc  = 0;
    bit        hold_req   = 1'b0;

    random_walk_patch_hit_tracker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Walker predictor
    // ------------------------------------------------------------------

    // CORDIC cosine/sine in Q2.30 of an angle given in 2^-32 turn.
    function automatic void rotate_unit(input bit [31:0] ang, output longint cs,
                                        output longint sn);
        bit [31:0] probe;
        bit        flip;
        longint    x;
        longint    y;
        longint    z;
        longint    nx;
        probe = ang + 32'h4000_0000;
        flip  = probe[31];
        if (flip)
        begin
            ang = ang ^ 32'h8000_0000;
        end
        x = CORDIC_START;
        y = 0;
        z = $signed(ang);
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_TURNS[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_TURNS[i];
            end
            x = nx;
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Exact test: squared distance strictly below (radius + perception)^2.
    function automatic bit inside_patch();
        bit [63:0]  reach;
        longint     dx;
        longint     dy;
        bit [63:0]  ax;
        bit [63:0]  ay;
        bit [127:0] dist_sq;
        bit [127:0] reach_sq;
        reach = 64'(patch_rad) + 64'(sense_rng);
        dx = walk_x - patch_cx;
        dy = walk_y - patch_cy;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax >= reach || ay >= reach)
        begin
            return 1'b0;
        end
        dist_sq  = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        reach_sq = 128'(reach) * 128'(reach);
        return dist_sq < reach_sq;
    endfunction

    // Advance the walker by one transfer; return 1 when a result is due.
    function automatic bit walker_advance(input in_item_t it, output out_item_t res);
        longint    cs;
        longint    sn;
        longint    len;
        bit [63:0] dt;
        res = '0;
        if (it.action == ACT_START)
        begin
            walk_x    = 0;
            walk_y    = 0;
            walk_time = 0;
            walk_hdg  = it.start_heading;
            walk_over = it.last;
            return it.last;
        end
        if (walk_over)
        begin
            return 1'b0;
        end
        walk_hdg = walk_hdg + 16'(it.turn_angle);
        rotate_unit({walk_hdg, 16'h0000}, cs, sn);
        len    = longint'({32'h0, it.step_length});
        walk_x = clamp_coord(walk_x + ((len * cs) >>> 30));
        walk_y = clamp_coord(walk_y + ((len * sn) >>> 30));
        dt = ({32'h0, time_rate} * {32'h0, it.step_length}) >> 16;
        walk_time = walk_time + dt;
        if (walk_time > 64'hFFFF_FFFF_FFFF)
        begin
            walk_time = 64'hFFFF_FFFF_FFFF;
        end
        if (inside_patch())
        begin
            walk_over    = 1'b1;
            res.hit      = 1'b1;
            res.hit_time = walk_time[47:0];
            return 1'b1;
        end
        if (it.last)
        begin
            walk_over = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: track config writes, predict on each input transfer and
    // compare each output transfer against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        item_tag_t tag;
        out_item_t res;
        out_item_t want;
        bit        due;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_PATCH_X:    patch_cx  = $signed(cfg_wdata);
                REG_PATCH_Y:    patch_cy  = $signed(cfg_wdata);
                REG_PATCH_RAD:  patch_rad = cfg_wdata;
                REG_PERCEPTION: sense_rng = cfg_wdata;
                REG_SPEED:      time_rate = cfg_wdata;
                default: ;
            endcase
        end
        if (in_valid && in_ready)
        begin
            tag = item_tags.pop_front();
            due = walker_advance(in_data, res);
            if (tag.typed)
            begin
                pending_results.push_back(tag.want);
            end
            else if (due)
            begin
                pending_results.push_back(res);
            end
        end
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result hit=%0b time=%h",
                         $time, out_data.hit, out_data.hit_time);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.hit !== want.hit)
                begin
                    $display("%0t: hit mismatch expected %0b actual %0b",
                             $time, want.hit, out_data.hit);
                    errors++;
                end
                if (out_data.hit_time !== want.hit_time)
                begin
                    $display("%0t: hit_time mismatch expected %h actual %h",
                             $time, want.hit_time, out_data.hit_time);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cyc <= 0;
        end
        else if (quiet_cyc >= STALL_LIMIT)
        begin
            $display("random_walk_patch_hit_tracker_unit verification failed");
            $finish;
        end
        else
        begin
            quiet_cyc <= quiet_cyc + 1;
        end
    end

    // Receiver: random back-pressure, mostly short, sometimes long; on
    // request hold off long enough for the block to fill and stall its input.
    initial
    begin
        int lo;
        int hi;
        int pick;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            lo = (pick < 60) ? 0 : (pick < 95) ? $urandom_range(1, 4) : $urandom_range(20, 80);
            hi = $urandom_range(1, 20);
            if (lo > 0)
            begin
                out_ready <= 1'b0;
                repeat (lo) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat (hi) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------

    // Offer one item after a random gap and hold it until the transfer.
    task automatic offer(input in_item_t it, input bit typed, input out_item_t want);
        item_tag_t tag;
        int        pick;
        int        gap;
        pick = $urandom_range(0, 99);
        gap  = (pick < 55) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tag.typed = typed;
        tag.want  = want;
        item_tags.push_back(tag);
        in_valid <= 1'b1;
        in_data  <= it;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    // Drop valid, drain every expected result and let the block go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_patch(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] rad, input logic [31:0] sense,
                              input logic [31:0] rate);
        write_reg(REG_PATCH_X, cx);
        write_reg(REG_PATCH_Y, cy);
        write_reg(REG_PATCH_RAD, rad);
        write_reg(REG_PERCEPTION, sense);
        write_reg(REG_SPEED, rate);
    endtask

    function automatic in_item_t make_item(input logic act, input logic [15:0] hdg,
                                           input logic [15:0] turn, input logic [31:0] len,
                                           input logic lst);
        in_item_t it;
        it.action        = act;
        it.start_heading = hdg;
        it.turn_angle    = turn;
        it.step_length   = len;
        it.last          = lst;
        return it;
    endfunction

    function automatic void add_row(input in_item_t it, input bit typed,
                                    input logic hit, input logic [47:0] t, input bit reconfig);
        stim_row_t row;
        row.item          = it;
        row.typed         = typed;
        row.want.hit      = hit;
        row.want.hit_time = t;
        row.reconfig      = reconfig;
        directed.push_back(row);
    endfunction

    // Random part of one phase: mostly whole walkers with random content,
    // some raw noise items.
    task automatic random_walkers(input int budget);
        int        sent;
        int        moves;
        int        pick;
        logic [31:0] len;
        out_item_t none;
        none = '0;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                offer(make_item(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                                $urandom, 1'($urandom_range(0, 1))), 1'b0, none);
                sent++;
            end
            else
            begin
                offer(make_item(ACT_START, 16'($urandom), 16'($urandom), $urandom,
                                $urandom_range(0, 19) == 0), 1'b0, none);
                sent++;
                moves = $urandom_range(1, 12);
                for (int m = 0; m < moves; m++)
                begin
                    pick = $urandom_range(0, 99);
                    len = (pick < 80) ? $urandom_range(0, 32'h0004_0000) :
                          (pick < 92) ? $urandom :
                          (pick < 96) ? 32'h0 : 32'hFFFF_FFFF;
                    offer(make_item(ACT_MOVE, 16'($urandom), 16'($urandom), len,
                                    (m == moves - 1) && ($urandom_range(0, 4) != 0)),
                          1'b0, none);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        out_item_t none;
        none = '0;

        // Reset settings (zero detection distance): nothing can hit.
        add_row(make_item(ACT_MOVE,  16'h0000, 16'h0000, 32'h0001_0000, 1'b0),
                1'b0, 1'b0, 48'h0, 1'b0);
        add_row(make_item(ACT_START, 16'h1234, 16'hFFFF, 32'hFFFF_FFFF, 1'b1),
                1'b1, 1'b0, 48'h0, 1'b0);
        add_row(make_item(ACT_START, 16'h0000, 16'h0000, 32'h0, 1'b0),
                1'b0, 1'b0, 48'h0, 1'b0);
        add_row(make_item(ACT_MOVE,  16'hFFFF, 16'h0000, 32'h0001_0000, 1'b1),
                1'b1, 1'b0, 48'h0, 1'b0);
        add_row(make_item(ACT_MOVE,  16'h0000, 16'h0000, 32'h0001_0000, 1'b1),
                1'b0, 1'b0, 48'h0, 1'b0);
        // Patch at (10, 0), reach 3: two steps of 4 along +x land inside.
        add_row(make_item(ACT_START, 16'h0000, 16'h0000, 32'h0, 1'b0),
                1'b0, 1'b0, 48'h0, 1'b1);
        add_row(make_item(ACT_MOVE,  16'h0000, 16'h0000, 32'h0004_0000, 1'b0),
                1'b0, 1'b0, 48'h0, 1'b0);
        add_row(make_item(ACT_MOVE,  16'h0000, 16'h0000, 32'h0004_0000, 1'b1),
                1'b1, 1'b1, 48'h0000_0008_0000, 1'b0);
        add_row(make_item(ACT_MOVE,  16'h0000, 16'h0000, 32'h0004_0000, 1'b1),
                1'b0, 1'b0, 48'h0, 1'b0);
        add_row(make_item(ACT_START, 16'h4000, 16'h0000, 32'h0, 1'b0),
                1'b0, 1'b0, 48'h0, 1'b0);
        add_row(make_item(ACT_MOVE,  16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b0),
                1'b0, 1'b0, 48'h0, 1'b0);
        add_row(make_item(ACT_MOVE,  16'h0000, 16'h8000, 32'h0, 1'b1),
                1'b0, 1'b0, 48'h0, 1'b0);
        add_row(make_item(ACT_START, 16'hFFFF, 16'h7FFF, 32'h0, 1'b1),
                1'b1, 1'b0, 48'h0, 1'b0);
        add_row(make_item(ACT_START, 16'h8000, 16'h0000, 32'h0, 1'b0),
                1'b0, 1'b0, 48'h0, 1'b0);
        add_row(make_item(ACT_MOVE,  16'h0000, 16'h7FFF, 32'h0001_0000, 1'b0),
                1'b0, 1'b0, 48'h0, 1'b0);
        add_row(make_item(ACT_MOVE,  16'h0000, 16'h8000, 32'h0000_FFFF, 1'b0),
                1'b0, 1'b0, 48'h0, 1'b0);
        add_row(make_item(ACT_MOVE,  16'h0000, 16'h4000, 32'h0008_0000, 1'b1),
                1'b0, 1'b0, 48'h0, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].reconfig)
            begin
                settle();
                load_patch(32'h000A_0000, 32'h0, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
            end
            offer(directed[i].item, directed[i].typed, directed[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // Pause until every expected result is in, then reconfigure.
            settle();
            case (p)
                0: load_patch(32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000,
                              32'h0000_8000, 32'h0001_0000);
                1: load_patch(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: load_patch(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
                3: load_patch(32'h8000_0000, 32'h7FFF_FFFF, 32'h4000_0000,
                              32'h2000_0000, 32'hFFFF_FFFF);
                default: load_patch($urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                                    $urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                                    $urandom_range(0, 32'h0004_0000),
                                    $urandom_range(0, 32'h0002_0000), $urandom);
            endcase
            // Fill the block against a stalled receiver once.
            if (p == 0)
            begin
                hold_req = 1'b1;
            end
            random_walkers(PHASE_ITEMS);
        end

        settle();
        if (errors == 0)
        begin
            $display("random_walk_patch_hit_tracker_unit verification clean");
        end
        else
        begin
            $display("random_walk_patch_hit_tracker_unit verification failed");
        end
        $finish;
    end

endmodule
